// ===== design/ppmd_pkg.sv =====
// shared types and constants of the ppm p6 stream decoder
`timescale 1ns / 1ps
package ppmd_pkg;

	localparam int COORD_W = 14;
	localparam int HDR_CNT_W = 4;

	localparam logic [7:0] CH_P    = 8'h50;
	localparam logic [7:0] CH_SIX  = 8'h36;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_LF   = 8'h0a;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic [HDR_CNT_W-1:0] MIN_FILE_BYTES = 4'd10;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_MAGIC = 3'd1,
		ST_ZERO_DIM  = 3'd2,
		ST_TRUNC     = 3'd3,
		ST_TOO_LARGE = 3'd4
	} status_t;

	// classified byte handed from the header parser to the pixel assembler
	typedef struct packed {
		logic [7:0] data_byte;
		logic       pix;
		logic       last;
		status_t    pre_status;
	} tok_t;

endpackage

// ===== design/ppmd_stream_if.sv =====
// valid/ready channel interfaces for byte input and pixel output
`timescale 1ns / 1ps
interface ppmd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface ppmd_out_if;
	logic        valid;
	logic        ready;
	logic        pixel_valid;
	logic [13:0] pixel_x;
	logic [13:0] pixel_y;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        done_res;
	logic [2:0]  status;

	modport source (output valid, output pixel_valid, output pixel_x, output pixel_y,
		output red, output green, output blue, output done_res, output status,
		input ready);
	modport sink (input valid, input pixel_valid, input pixel_x, input pixel_y,
		input red, input green, input blue, input done_res, input status,
		output ready);
endinterface

// ===== design/ppm_p6_stream_decoder_core.sv =====
// top level of the ppm p6 stream decoder
// usage:
//   in_ch carries the file one byte per transfer, with last set on the final byte.
//   out_ch carries one result per completed pixel and one on the final byte;
//   a final byte that also completes a pixel gives a single result with both.
//   pixel results carry x, y in raster order and r, g, b; the final result
//   carries done_res and status (0 ok, 1 bad magic or short file, 2 zero size,
//   3 truncated, 4 over MAX_DIM). on a nonzero status the user discards the pixels; the block does not.
// path: a byte goes through the token queue, then the output register, before its result shows.
// throughput: one byte per cycle while the output is not stalled; the header parser decides
//   each byte as it is taken and the pixel assembler drains the token queue at the same rate.
// stall: a stalled output holds its result; the four-entry token queue keeps
//   taking bytes until full, then in_ch.ready drops. bytes that give no result
//   still drain past a stalled output.
// reset: arst_n clears the parser, queue and output; the block waits for the
//   first byte of a file. after each final byte it returns to that state.
`timescale 1ns / 1ps
module ppm_p6_stream_decoder_core #(
	parameter int MAX_DIM = 16383
) (
	input  logic       clk,
	input  logic       arst_n,
	ppmd_in_if.sink    in_ch,
	ppmd_out_if.source out_ch
);
	import ppmd_pkg::*;

	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int TW = $bits(tok_t);
	localparam int FW = TW + 2 * DW;

	tok_t          f_tok;
	logic [DW-1:0] f_width;
	logic [DW-1:0] f_height;
	logic          q_full;
	logic          q_valid;
	logic          q_pop;
	logic [FW-1:0] q_rdata;
	tok_t          b_tok;
	logic [DW-1:0] b_width;
	logic [DW-1:0] b_height;
	logic          in_xfer;

	assign in_ch.ready = !q_full;
	assign in_xfer     = in_ch.valid && !q_full;

	ppmd_front #(.MAX_DIM(MAX_DIM)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_xfer),
		.data_byte  (in_ch.data_byte),
		.last       (in_ch.last),
		.tok        (f_tok),
		.tok_width  (f_width),
		.tok_height (f_height)
	);

	ppmd_fifo #(.WIDTH(FW), .DEPTH(4)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_xfer),
		.wdata     ({f_tok, f_width, f_height}),
		.full      (q_full),
		.pop       (q_pop),
		.rdata     (q_rdata),
		.not_empty (q_valid)
	);

	assign b_tok    = q_rdata[FW-1 -: TW];
	assign b_width  = q_rdata[2*DW-1 -: DW];
	assign b_height = q_rdata[DW-1:0];

	ppmd_back #(.MAX_DIM(MAX_DIM)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok_valid  (q_valid),
		.tok        (b_tok),
		.tok_width  (b_width),
		.tok_height (b_height),
		.tok_pop    (q_pop),
		.out_ch     (out_ch)
	);
endmodule

// ===== design/ppmd_fifo.sv =====
// small flop based fifo between the header parser and the pixel assembler
`timescale 1ns / 1ps
module ppmd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             not_empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = mem_q[rptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ===== design/ppmd_front.sv =====
// header parser: accepts file bytes, reads the header and classifies each byte
`timescale 1ns / 1ps
module ppmd_front #(
	parameter int MAX_DIM = 16383
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            data_byte,
	input  logic                  last,
	output ppmd_pkg::tok_t        tok,
	output logic [$clog2(MAX_DIM+1)-1:0] tok_width,
	output logic [$clog2(MAX_DIM+1)-1:0] tok_height
);
	import ppmd_pkg::*;

	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int SW = DW + 5;

	typedef enum logic [3:0] {
		PH_MAGIC0   = 4'd0,
		PH_MAGIC1   = 4'd1,
		PH_SKIP     = 4'd2,
		PH_CMTSTART = 4'd3,
		PH_CMT      = 4'd4,
		PH_WIDTH    = 4'd5,
		PH_SEP      = 4'd6,
		PH_HEIGHT   = 4'd7,
		PH_REST     = 4'd8,
		PH_MAXVAL   = 4'd9,
		PH_PIXELS   = 4'd10,
		PH_DONE     = 4'd11,
		PH_IGNORE   = 4'd12
	} phase_t;

	phase_t                 phase_q, ph;
	logic [HDR_CNT_W-1:0]   hcnt_q, hcnt_n;
	logic [DW-1:0]          width_q, w_n;
	logic [DW-1:0]          height_q, h_n;
	logic [2:0]             err_q, e_n;
	logic                   cont;
	logic                   is_digit;
	logic [3:0]             digit;
	logic [SW-1:0]          wsum;
	logic [SW-1:0]          hsum;
	logic                   w_ovf;
	logic                   h_ovf;
	logic                   pix;
	status_t                pre;

	assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	assign digit    = 4'(data_byte - CH_ZERO);
	assign wsum     = SW'(width_q) * SW'(10) + SW'(digit);
	assign hsum     = SW'(height_q) * SW'(10) + SW'(digit);
	assign w_ovf    = wsum > SW'(MAX_DIM);
	assign h_ovf    = hsum > SW'(MAX_DIM);

	always_comb begin
		ph     = phase_q;
		w_n    = width_q;
		h_n    = height_q;
		e_n    = err_q;
		pix    = 1'b0;
		cont   = 1'b0;
		hcnt_n = (hcnt_q < MIN_FILE_BYTES) ? hcnt_q + 1'b1 : hcnt_q;
		case (phase_q)
			PH_MAGIC0: begin
				if (data_byte == CH_P) begin
					ph = PH_MAGIC1;
				end else begin
					ph  = PH_IGNORE;
					e_n = 3'(ST_BAD_MAGIC);
				end
			end
			PH_MAGIC1: begin
				if (data_byte == CH_SIX) begin
					ph = PH_SKIP;
				end else begin
					ph  = PH_IGNORE;
					e_n = 3'(ST_BAD_MAGIC);
				end
			end
			PH_SKIP: ph = PH_CMTSTART;
			PH_CMT: begin
				if (data_byte == CH_LF) begin
					ph = PH_CMTSTART;
				end
			end
			PH_MAXVAL: begin
				if (data_byte == CH_LF) begin
					ph = (width_q == '0 || height_q == '0) ? PH_DONE : PH_PIXELS;
				end
			end
			PH_PIXELS: pix = 1'b1;
			PH_DONE, PH_IGNORE: ;
			default: begin
				// header phases may hand the byte on to the next phase
				cont = 1'b1;
				if (ph == PH_CMTSTART) begin
					if (data_byte == CH_HASH) begin
						ph   = PH_CMT;
						cont = 1'b0;
					end else begin
						ph = PH_WIDTH;
					end
				end
				if (cont && ph == PH_WIDTH) begin
					if (is_digit) begin
						w_n  = w_ovf ? DW'(MAX_DIM) : DW'(wsum);
						e_n  = w_ovf ? 3'(ST_TOO_LARGE) : e_n;
						cont = 1'b0;
					end else begin
						ph = PH_SEP;
					end
				end
				if (cont && ph == PH_SEP) begin
					if (data_byte == CH_SP || data_byte == CH_LF) begin
						cont = 1'b0;
					end else begin
						ph = PH_HEIGHT;
					end
				end
				if (cont && ph == PH_HEIGHT) begin
					if (is_digit) begin
						h_n  = h_ovf ? DW'(MAX_DIM) : DW'(hsum);
						e_n  = h_ovf ? 3'(ST_TOO_LARGE) : e_n;
						cont = 1'b0;
					end else begin
						ph = PH_REST;
					end
				end
				if (cont && ph == PH_REST) begin
					if (data_byte == CH_LF) begin
						ph = PH_MAXVAL;
					end
					cont = 1'b0;
				end
				if (cont) begin
					ph = PH_IGNORE;
				end
			end
		endcase

		if (e_n == 3'(ST_BAD_MAGIC) || hcnt_n < MIN_FILE_BYTES) begin
			pre = ST_BAD_MAGIC;
		end else if (w_n == '0 || h_n == '0) begin
			pre = ST_ZERO_DIM;
		end else if (e_n == 3'(ST_TOO_LARGE)) begin
			pre = ST_TOO_LARGE;
		end else begin
			pre = ST_OK;
		end
	end

	assign tok.data_byte  = data_byte;
	assign tok.pix        = pix;
	assign tok.last       = last;
	assign tok.pre_status = pre;
	assign tok_width      = w_n;
	assign tok_height     = h_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_MAGIC0;
			hcnt_q   <= '0;
			width_q  <= '0;
			height_q <= '0;
			err_q    <= '0;
		end else if (accept) begin
			if (last) begin
				phase_q  <= PH_MAGIC0;
				hcnt_q   <= '0;
				width_q  <= '0;
				height_q <= '0;
				err_q    <= '0;
			end else begin
				phase_q  <= ph;
				hcnt_q   <= hcnt_n;
				width_q  <= w_n;
				height_q <= h_n;
				err_q    <= e_n;
			end
		end
	end
endmodule

// ===== design/ppmd_back.sv =====
// pixel assembler: groups pixel bytes into rgb results and closes each file
`timescale 1ns / 1ps
module ppmd_back #(
	parameter int MAX_DIM = 16383
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         tok_valid,
	input  ppmd_pkg::tok_t               tok,
	input  logic [$clog2(MAX_DIM+1)-1:0] tok_width,
	input  logic [$clog2(MAX_DIM+1)-1:0] tok_height,
	output logic                         tok_pop,
	ppmd_out_if.source                   out_ch
);
	import ppmd_pkg::*;

	localparam int DW = $clog2(MAX_DIM + 1);

	logic [1:0]      chan_q;
	logic [7:0]      red_q;
	logic [7:0]      green_q;
	logic [DW-1:0]   col_q;
	logic [DW-1:0]   row_q;
	logic            done_q;
	logic [DW:0]     col_inc;
	logic [DW:0]     row_inc;
	logic            pix_done;
	logic            wrap;
	logic            img_end;
	logic            produce;
	status_t         fin_status;

	logic            ov_q;
	logic            opix_q;
	logic [COORD_W-1:0] ox_q;
	logic [COORD_W-1:0] oy_q;
	logic [7:0]      or_q;
	logic [7:0]      og_q;
	logic [7:0]      ob_q;
	logic            odone_q;
	status_t         ost_q;

	assign col_inc  = {1'b0, col_q} + 1'b1;
	assign row_inc  = {1'b0, row_q} + 1'b1;
	assign pix_done = tok.pix && !done_q && (chan_q == 2'd2);
	assign wrap     = col_inc >= {1'b0, tok_width};
	assign img_end  = pix_done && wrap && (row_inc >= {1'b0, tok_height});
	assign produce  = pix_done || tok.last;
	assign tok_pop  = tok_valid && (!produce || !ov_q || out_ch.ready);

	always_comb begin
		if (tok.pre_status != ST_OK) begin
			fin_status = tok.pre_status;
		end else if (done_q || img_end) begin
			fin_status = ST_OK;
		end else begin
			fin_status = ST_TRUNC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q  <= '0;
			col_q   <= '0;
			row_q   <= '0;
			done_q  <= 1'b0;
			red_q   <= '0;
			green_q <= '0;
		end else if (tok_pop) begin
			if (tok.last) begin
				chan_q  <= '0;
				col_q   <= '0;
				row_q   <= '0;
				done_q  <= 1'b0;
				red_q   <= '0;
				green_q <= '0;
			end else if (tok.pix && !done_q) begin
				case (chan_q)
					2'd0: begin
						red_q  <= tok.data_byte;
						chan_q <= 2'd1;
					end
					2'd1: begin
						green_q <= tok.data_byte;
						chan_q  <= 2'd2;
					end
					default: begin
						chan_q <= 2'd0;
						if (wrap) begin
							col_q <= '0;
							row_q <= DW'(row_inc);
						end else begin
							col_q <= DW'(col_inc);
						end
						done_q <= img_end;
					end
				endcase
			end
		end
	end

	// output register, refilled in the same cycle it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (tok_pop && produce) begin
			ov_q <= 1'b1;
		end else if (out_ch.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_pop && produce) begin
			opix_q  <= pix_done;
			ox_q    <= pix_done ? COORD_W'(col_q) : '0;
			oy_q    <= pix_done ? COORD_W'(row_q) : '0;
			or_q    <= pix_done ? red_q : '0;
			og_q    <= pix_done ? green_q : '0;
			ob_q    <= pix_done ? tok.data_byte : '0;
			odone_q <= tok.last;
			ost_q   <= tok.last ? fin_status : ST_OK;
		end
	end

	assign out_ch.valid       = ov_q;
	assign out_ch.pixel_valid = opix_q;
	assign out_ch.pixel_x     = ox_q;
	assign out_ch.pixel_y     = oy_q;
	assign out_ch.red         = or_q;
	assign out_ch.green       = og_q;
	assign out_ch.blue        = ob_q;
	assign out_ch.done_res    = odone_q;
	assign out_ch.status      = 3'(ost_q);
endmodule

// ===== design/ppmd_checker.sv =====
// port level checks on the decoder output, bound to the top level
`timescale 1ns / 1ps
module ppmd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic        pixel_valid,
	input logic [7:0]  red,
	input logic [7:0]  green,
	input logic [7:0]  blue,
	input logic [13:0] pixel_x,
	input logic [13:0] pixel_y,
	input logic        done_res,
	input logic [2:0]  status
);
	import ppmd_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(pixel_x) && $stable(status))
		else $error("output changed while stalled");

	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> pixel_valid || done_res)
		else $error("result with neither pixel nor done");

	a_status_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !done_res |-> status == 3'(ST_OK))
		else $error("status set without done");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !pixel_valid |-> red == 8'd0 && green == 8'd0 && blue == 8'd0 &&
			pixel_x == 14'd0 && pixel_y == 14'd0)
		else $error("pixel fields nonzero on status only result");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid && done_res |-> status == 3'(ST_OK) || status == 3'(ST_BAD_MAGIC) ||
			status == 3'(ST_ZERO_DIM) || status == 3'(ST_TRUNC) ||
			status == 3'(ST_TOO_LARGE))
		else $error("status code out of range");
endmodule

bind ppm_p6_stream_decoder_core ppmd_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.valid       (out_ch.valid),
	.ready       (out_ch.ready),
	.pixel_valid (out_ch.pixel_valid),
	.red         (out_ch.red),
	.green       (out_ch.green),
	.blue        (out_ch.blue),
	.pixel_x     (out_ch.pixel_x),
	.pixel_y     (out_ch.pixel_y),
	.done_res    (out_ch.done_res),
	.status      (out_ch.status)
);

// ===== tb/ppm_p6_stream_decoder_core_tb.sv =====
// self-checking testbench for the ppm p6 stream decoder: directed files, then random files
`timescale 1ns / 1ps
module ppm_p6_stream_decoder_core_tb;
	import ppmd_pkg::*;

	localparam int MAX_DIM = 16383;
	localparam int ITEM_TARGET = 1150;
	localparam int IDLE_LIMIT = 2000;

	typedef enum logic [3:0] {
		P_MAG0, P_MAG1, P_SKIP, P_CMT_START, P_CMT, P_WIDTH, P_SEP,
		P_HEIGHT, P_REST, P_MAXVAL, P_PIXELS, P_DONE, P_IGNORE
	} phase_t;

	typedef struct packed {
		logic               pix;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic               done;
		status_t            status;
	} out_rec_t;

	typedef struct packed {
		logic [7:0] b;
		logic       fin;
		logic       typed;
		out_rec_t   res;
	} dir_row_t;

	localparam out_rec_t NO_OUT = '0;
	localparam out_rec_t DONE_BAD = '{1'b0, 14'd0, 14'd0, 8'd0, 8'd0, 8'd0, 1'b1, ST_BAD_MAGIC};
	localparam out_rec_t DONE_ZERO = '{1'b0, 14'd0, 14'd0, 8'd0, 8'd0, 8'd0, 1'b1, ST_ZERO_DIM};
	localparam out_rec_t ONE_PIXEL_END =
		'{1'b1, 14'd0, 14'd0, 8'h00, 8'hff, 8'h80, 1'b1, ST_OK};

	// single bytes, a 1x1 image, then a zero-width image
	localparam dir_row_t DIR_ROWS [26] = '{
		'{8'h58, 1'b1, 1'b1, DONE_BAD},
		'{8'hff, 1'b1, 1'b1, DONE_BAD},
		'{CH_P, 1'b0, 1'b0, NO_OUT},
		'{CH_SIX, 1'b0, 1'b0, NO_OUT},
		'{CH_LF, 1'b0, 1'b0, NO_OUT},
		'{8'h31, 1'b0, 1'b0, NO_OUT},
		'{CH_SP, 1'b0, 1'b0, NO_OUT},
		'{8'h31, 1'b0, 1'b0, NO_OUT},
		'{CH_LF, 1'b0, 1'b0, NO_OUT},
		'{8'h32, 1'b0, 1'b0, NO_OUT},
		'{8'h35, 1'b0, 1'b0, NO_OUT},
		'{8'h35, 1'b0, 1'b0, NO_OUT},
		'{CH_LF, 1'b0, 1'b0, NO_OUT},
		'{8'h00, 1'b0, 1'b0, NO_OUT},
		'{8'hff, 1'b0, 1'b0, NO_OUT},
		'{8'h80, 1'b1, 1'b1, ONE_PIXEL_END},
		'{CH_P, 1'b0, 1'b0, NO_OUT},
		'{CH_SIX, 1'b0, 1'b0, NO_OUT},
		'{CH_LF, 1'b0, 1'b0, NO_OUT},
		'{CH_ZERO, 1'b0, 1'b0, NO_OUT},
		'{CH_SP, 1'b0, 1'b0, NO_OUT},
		'{8'h35, 1'b0, 1'b0, NO_OUT},
		'{CH_LF, 1'b0, 1'b0, NO_OUT},
		'{8'h41, 1'b0, 1'b0, NO_OUT},
		'{CH_LF, 1'b0, 1'b0, NO_OUT},
		'{8'h5a, 1'b1, 1'b1, DONE_ZERO}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit steady = 1'b0;

	ppmd_in_if in_ch ();
	ppmd_out_if out_ch ();

	ppm_p6_stream_decoder_core #(
		.MAX_DIM(MAX_DIM)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// decoder state mirror
	phase_t dec_phase;
	logic [HDR_CNT_W-1:0] dec_count;
	logic [COORD_W-1:0] dec_w, dec_h, dec_col, dec_row;
	logic [1:0] dec_chan;
	logic [7:0] dec_red, dec_green;
	status_t dec_err;

	out_rec_t decoded_q [$];
	logic [7:0] file_q [$];

	int fails = 0;
	int n_bytes = 0;
	int n_files = 0;
	int n_pix = 0;
	int n_eof = 0;
	int st_count [8];
	int idle_cycles = 0;

	task automatic clear_decoder();
		dec_phase = P_MAG0;
		dec_count = '0;
		dec_w = '0;
		dec_h = '0;
		dec_col = '0;
		dec_row = '0;
		dec_chan = '0;
		dec_red = '0;
		dec_green = '0;
		dec_err = ST_OK;
	endtask

	function automatic logic [COORD_W-1:0] push_digit(logic [COORD_W-1:0] v, logic [7:0] b);
		int n;
		n = int'(v) * 10 + int'(b - CH_ZERO);
		if (n > MAX_DIM) begin
			dec_err = ST_TOO_LARGE;
			n = MAX_DIM;
		end
		return COORD_W'(n);
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic fin, output logic hit,
			output out_rec_t rec);
		logic fwd;
		rec = NO_OUT;
		if (dec_count < MIN_FILE_BYTES)
			dec_count = dec_count + 1'b1;
		case (dec_phase)
			P_MAG0: begin
				if (b == CH_P) begin
					dec_phase = P_MAG1;
				end else begin
					dec_phase = P_IGNORE;
					dec_err = ST_BAD_MAGIC;
				end
			end
			P_MAG1: begin
				if (b == CH_SIX) begin
					dec_phase = P_SKIP;
				end else begin
					dec_phase = P_IGNORE;
					dec_err = ST_BAD_MAGIC;
				end
			end
			P_SKIP: dec_phase = P_CMT_START;
			P_CMT: if (b == CH_LF) dec_phase = P_CMT_START;
			P_MAXVAL: begin
				if (b == CH_LF)
					dec_phase = (dec_w == 0 || dec_h == 0) ? P_DONE : P_PIXELS;
			end
			P_PIXELS: begin
				case (dec_chan)
					2'd0: begin
						dec_red = b;
						dec_chan = 2'd1;
					end
					2'd1: begin
						dec_green = b;
						dec_chan = 2'd2;
					end
					default: begin
						rec.pix = 1'b1;
						rec.x = dec_col;
						rec.y = dec_row;
						rec.red = dec_red;
						rec.green = dec_green;
						rec.blue = b;
						dec_chan = 2'd0;
						dec_col = dec_col + 1'b1;
						if (dec_col >= dec_w) begin
							dec_col = '0;
							dec_row = dec_row + 1'b1;
							if (dec_row >= dec_h)
								dec_phase = P_DONE;
						end
					end
				endcase
			end
			P_DONE, P_IGNORE: ;
			default: begin
				// header phases may pass the same byte on to the next phase
				fwd = 1'b1;
				while (fwd) begin
					fwd = 1'b0;
					case (dec_phase)
						P_CMT_START: begin
							if (b == CH_HASH) begin
								dec_phase = P_CMT;
							end else begin
								dec_phase = P_WIDTH;
								fwd = 1'b1;
							end
						end
						P_WIDTH: begin
							if (b >= CH_ZERO && b <= CH_NINE) begin
								dec_w = push_digit(dec_w, b);
							end else begin
								dec_phase = P_SEP;
								fwd = 1'b1;
							end
						end
						P_SEP: begin
							if (b != CH_SP && b != CH_LF) begin
								dec_phase = P_HEIGHT;
								fwd = 1'b1;
							end
						end
						P_HEIGHT: begin
							if (b >= CH_ZERO && b <= CH_NINE) begin
								dec_h = push_digit(dec_h, b);
							end else begin
								dec_phase = P_REST;
								fwd = 1'b1;
							end
						end
						default: if (b == CH_LF) dec_phase = P_MAXVAL;
					endcase
				end
			end
		endcase
		hit = rec.pix || fin;
		if (fin) begin
			rec.done = 1'b1;
			if (dec_err == ST_BAD_MAGIC || dec_count < MIN_FILE_BYTES)
				rec.status = ST_BAD_MAGIC;
			else if (dec_w == 0 || dec_h == 0)
				rec.status = ST_ZERO_DIM;
			else if (dec_err == ST_TOO_LARGE)
				rec.status = ST_TOO_LARGE;
			else if (dec_phase != P_DONE)
				rec.status = ST_TRUNC;
			else
				rec.status = ST_OK;
			clear_decoder();
		end
	endtask

	function automatic logic [7:0] other_than(logic [7:0] avoid);
		logic [7:0] v;
		v = 8'($urandom_range(255));
		if (v == avoid)
			v = ~avoid;
		return v;
	endfunction

	task automatic add_byte(input logic [7:0] b);
		file_q.insert(file_q.size(), b);
	endtask

	task automatic push_dec(input int v);
		string s;
		s = $sformatf("%0d", v);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic build_file();
		int pick, w, h, n_px, n_tail, keep;
		file_q.delete();
		pick = $urandom_range(99);
		// noise, sometimes behind a valid magic
		if (pick >= 94) begin
			if ($urandom_range(1)) begin
				add_byte(CH_P);
				add_byte(CH_SIX);
			end
			repeat ($urandom_range(1, 24)) add_byte(8'($urandom_range(255)));
			return;
		end
		// bad magic
		if (pick >= 88) begin
			if ($urandom_range(1)) begin
				add_byte(CH_P);
				add_byte(other_than(CH_SIX));
			end else begin
				add_byte(other_than(CH_P));
			end
			repeat ($urandom_range(15)) add_byte(8'($urandom_range(255)));
			return;
		end
		w = $urandom_range(1, 5);
		h = $urandom_range(1, 4);
		if ($urandom_range(19) == 0) begin
			w = $urandom_range(6, 40);
			h = 1;
		end
		n_px = 3 * w * h;
		n_tail = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
		if (pick >= 76 && pick < 82) begin
			if ($urandom_range(1))
				w = 0;
			else
				h = 0;
			n_px = $urandom_range(6);
		end else if (pick >= 70 && pick < 76) begin
			case ($urandom_range(3))
				0: w = $urandom_range(16384, 99999);
				1: w = MAX_DIM;
				2: h = $urandom_range(16384, 99999);
				default: w = MAX_DIM + 1;
			endcase
			n_px = $urandom_range(12);
			n_tail = 0;
		end else if (pick >= 62 && pick < 70) begin
			n_px = n_px - $urandom_range(1, n_px);
			n_tail = 0;
		end
		add_byte(CH_P);
		add_byte(CH_SIX);
		add_byte($urandom_range(3) ? CH_LF : 8'($urandom_range(255)));
		repeat ($urandom_range(2)) begin
			add_byte(CH_HASH);
			repeat ($urandom_range(6)) add_byte(other_than(CH_LF));
			add_byte(CH_LF);
		end
		if ($urandom_range(4) == 0)
			add_byte(CH_ZERO);
		push_dec(w);
		repeat ($urandom_range(1, 3)) add_byte($urandom_range(1) ? CH_SP : CH_LF);
		push_dec(h);
		if ($urandom_range(2) == 0) begin
			add_byte(CH_SP);
			repeat ($urandom_range(3)) add_byte(other_than(CH_LF));
		end
		add_byte(CH_LF);
		if ($urandom_range(3))
			push_dec(255);
		else
			repeat ($urandom_range(4)) add_byte(other_than(CH_LF));
		add_byte(CH_LF);
		repeat (n_px + n_tail) add_byte(8'($urandom_range(255)));
		// short file
		if (pick >= 82) begin
			keep = $urandom_range(1, 9);
			while (file_q.size() > keep)
				void'(file_q.pop_back());
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
			input out_rec_t typed_rec);
		logic hit;
		out_rec_t rec;
		while (!steady && $urandom_range(99) < 21) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.last <= fin;
		@(negedge clk);
		while (!in_ch.ready)
			@(negedge clk);
		@(posedge clk);
		decode_byte(b, fin, hit, rec);
		if (typed)
			decoded_q.insert(decoded_q.size(), typed_rec);
		else if (hit)
			decoded_q.insert(decoded_q.size(), rec);
		n_bytes++;
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			fails++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	initial forever begin
		@(posedge clk);
		out_ch.ready <= steady || ($urandom_range(99) >= 21);
	end

	always @(negedge clk) begin
		out_rec_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_ch.pixel_valid, out_ch.pixel_x, out_ch.pixel_y, out_ch.red,
				out_ch.green, out_ch.blue, out_ch.done_res, status_t'(out_ch.status)};
			if (got.pix)
				n_pix++;
			if (got.done) begin
				n_eof++;
				st_count[got.status]++;
			end
			if (decoded_q.size() == 0) begin
				fails++;
				$display("%0t: transfer with nothing pending, expected none, actual %h",
					$time, got);
			end else begin
				want = decoded_q.pop_front();
				check_field("pixel_valid", want.pix, got.pix);
				check_field("pixel_x", want.x, got.x);
				check_field("pixel_y", want.y, got.y);
				check_field("red", want.red, got.red);
				check_field("green", want.green, got.green);
				check_field("blue", want.blue, got.blue);
				check_field("done_res", want.done, got.done);
				check_field("status", want.status, got.status);
			end
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(negedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no transfer for %0d cycles, %0d results pending", $time, IDLE_LIMIT,
			decoded_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.last = 1'b0;
		out_ch.ready = 1'b0;
		clear_decoder();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(DIR_ROWS); i++)
			send_byte(DIR_ROWS[i].b, DIR_ROWS[i].fin, DIR_ROWS[i].typed, DIR_ROWS[i].res);
		n_files = 4;

		while (n_bytes < ITEM_TARGET) begin
			steady <= (n_bytes >= 500 && n_bytes < 700);
			build_file();
			n_files++;
			for (int i = 0; i < file_q.size(); i++)
				send_byte(file_q[i], i == file_q.size() - 1, 1'b0, NO_OUT);
		end
		steady <= 1'b0;
		in_ch.valid <= 1'b0;

		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("streamed %0d files in %0d bytes: %0d pixel transfers, %0d end-of-file transfers",
			n_files, n_bytes, n_pix, n_eof);
		$display("end status seen: ok %0d, magic/short %0d, zero size %0d, truncated %0d, large %0d",
			st_count[ST_OK], st_count[ST_BAD_MAGIC], st_count[ST_ZERO_DIM], st_count[ST_TRUNC],
			st_count[ST_TOO_LARGE]);
		if (fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== ppm_p6_stream_decoder_core.f =====
design/ppmd_pkg.sv
design/ppmd_stream_if.sv
design/ppmd_fifo.sv
design/ppmd_front.sv
design/ppmd_back.sv
design/ppm_p6_stream_decoder_core.sv
design/ppmd_checker.sv
tb/ppm_p6_stream_decoder_core_tb.sv
